@@ src/adjacency_matrix_dfs_order_assert.svh @@
// Assertion macros shared by the depth-first order block.
`ifndef ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define AMDFS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A trigger in one cycle implies a condition in the same cycle.
`define AMDFS_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// A trigger in one cycle implies a condition in the next cycle.
`define AMDFS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/amdfs_pkg.sv @@
// Types and constants of the depth-first order block.
package amdfs_pkg;

    localparam int VERTEX_W = 5;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FLUSH
    } amdfs_state_t;

endpackage

@@ src/amdfs_ffs.sv @@
// Find-first-set unit: index of the lowest set bit of a mask, by halving search.
module amdfs_ffs #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]                          mask,
    output logic                                      any,
    output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] index
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int W2 = 1 << IW;

    logic [W2-1:0] work;
    logic [W2-1:0] low_half;
    logic [IW-1:0] idx;

    // Each level looks at the low half of what is left; if it is empty,
    // the answer lies in the high half and that half is shifted down.
    always_comb begin
        work     = W2'(mask);
        low_half = '0;
        idx      = '0;
        for (int l = IW - 1; l >= 0; l--) begin
            low_half = {W2{1'b1}} >> (W2 - (1 << l));
            if (!(|(work & low_half))) begin
                idx[l] = 1'b1;
                work   = work >> (1 << l);
            end
        end
    end

    assign any   = |mask;
    assign index = idx;

endmodule

@@ src/adjacency_matrix_dfs_order.sv @@
// Depth-first visit order over an adjacency bit matrix, top level.
//
// Usage: items arrive on the s_ channel (s_cmd, s_vertex_a, s_vertex_b) with
// s_valid/s_ready; results leave on the m_ channel (m_visited_vertex, m_found,
// m_last) with m_valid/m_ready. cfg_wr_en with cfg_wr_data sets the directed
// flag, which is registered; write it only while the block is idle.
// Add-vertex and add-edge items are taken while idle and applied directly.
// A run item occupies the sequencer: each cycle it either pushes one vertex
// (found by the shared find-first-set unit) or pops one off the walk stack,
// but a push waits while a result is held and the output is stalled.
// Each result is held back one step so that the final one can carry m_last:
// a result is registered when the next vertex is pushed, and the final one
// in the flush state after the last pop. When the first root has a present
// neighbour, the first result appears once that neighbour is pushed; an
// empty graph gets a not-found result. s_ready is low for the whole run.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before it produces another; nothing is dropped.
// Reset clears the edge matrix and the present and visited maps, sets the
// directed flag to 1 and clears all control state, leaving the block idle.
`include "adjacency_matrix_dfs_order_assert.svh"

module adjacency_matrix_dfs_order
    import amdfs_pkg::*;
#(
    parameter int NUM_VERTICES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [VERTEX_W-1:0] s_vertex_a,
    input  logic [VERTEX_W-1:0] s_vertex_b,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [VERTEX_W-1:0] m_visited_vertex,
    output logic                m_found,
    output logic                m_last
);

    // Only vertices that the 5-bit fields can name are ever stored.
    localparam int NV = (NUM_VERTICES > (1 << VERTEX_W)) ? (1 << VERTEX_W) : NUM_VERTICES;
    localparam int IW = $clog2(NV);
    localparam int DW = $clog2(NV + 1);

    amdfs_state_t state_reg, state_next;

    logic                directed_reg, directed_next;
    logic [NV-1:0]       present_reg, present_next;
    logic [NV-1:0]       visited_reg, visited_next;
    logic [NV-1:0]       edge_reg [NV];
    logic [NV-1:0]       edge_next [NV];
    logic [IW-1:0]       stack_reg [NV];
    logic [DW-1:0]       depth_reg, depth_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [IW-1:0]       hold_vertex_reg, hold_vertex_next;
    logic                m_valid_reg, m_valid_next;
    logic [VERTEX_W-1:0] m_vertex_reg, m_vertex_next;
    logic                m_found_reg, m_found_next;
    logic                m_last_reg, m_last_next;

    logic                s_accept;
    logic                out_free;
    logic                a_ok;
    logic                b_ok;
    logic [IW-1:0]       a_idx;
    logic [IW-1:0]       b_idx;
    logic                stack_empty;
    logic [IW-1:0]       top_idx;
    logic [IW-1:0]       top_vertex;
    logic [NV-1:0]       cand;
    logic                cand_any;
    logic [IW-1:0]       cand_idx;
    logic                step_push;
    logic                step_pop;
    logic                step_done;
    logic                flush_go;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign a_ok  = {1'b0, s_vertex_a} < (VERTEX_W + 1)'(NV);
    assign b_ok  = {1'b0, s_vertex_b} < (VERTEX_W + 1)'(NV);
    assign a_idx = s_vertex_a[IW-1:0];
    assign b_idx = s_vertex_b[IW-1:0];

    assign stack_empty = (depth_reg == '0);
    assign top_idx     = IW'(depth_reg - DW'(1));
    assign top_vertex  = stack_reg[top_idx];

    // With an empty stack the same search picks the next root: every
    // present vertex below it has already been visited.
    assign cand = stack_empty ? (present_reg & ~visited_reg)
                              : (edge_reg[top_vertex] & present_reg & ~visited_reg);

    amdfs_ffs #(
        .WIDTH (NV)
    ) u_ffs (
        .mask  (cand),
        .any   (cand_any),
        .index (cand_idx)
    );

    // A push must first move any held result out, so it waits on the output when one is held.
    assign step_push = (state_reg == ST_STEP) && cand_any && (!hold_valid_reg || out_free);
    assign step_pop  = (state_reg == ST_STEP) && !cand_any && !stack_empty;
    assign step_done = (state_reg == ST_STEP) && !cand_any && stack_empty;
    assign flush_go  = (state_reg == ST_FLUSH) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_cmd == CMD_RUN) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (step_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (flush_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        directed_next    = cfg_wr_en ? cfg_wr_data : directed_reg;
        present_next     = present_reg;
        visited_next     = visited_reg;
        edge_next        = edge_reg;
        depth_next       = depth_reg;
        hold_valid_next  = hold_valid_reg;
        hold_vertex_next = hold_vertex_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_vertex_next    = m_vertex_reg;
        m_found_next     = m_found_reg;
        m_last_next      = m_last_reg;

        if (s_accept) begin
            case (s_cmd)
                CMD_ADD_VERTEX: begin
                    if (a_ok) begin
                        present_next[a_idx] = 1'b1;
                    end
                end
                CMD_ADD_EDGE: begin
                    if (a_ok && b_ok) begin
                        edge_next[a_idx][b_idx] = 1'b1;
                        if (!directed_reg) begin
                            edge_next[b_idx][a_idx] = 1'b1;
                        end
                    end
                end
                CMD_RUN: begin
                    visited_next    = '0;
                    depth_next      = '0;
                    hold_valid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (step_push) begin
            visited_next[cand_idx] = 1'b1;
            depth_next             = depth_reg + DW'(1);
            hold_valid_next        = 1'b1;
            hold_vertex_next       = cand_idx;
            if (hold_valid_reg) begin
                m_valid_next  = 1'b1;
                m_vertex_next = VERTEX_W'(hold_vertex_reg);
                m_found_next  = 1'b1;
                m_last_next   = 1'b0;
            end
        end

        if (step_pop) begin
            depth_next = depth_reg - DW'(1);
        end

        if (flush_go) begin
            m_valid_next    = 1'b1;
            m_vertex_next   = hold_valid_reg ? VERTEX_W'(hold_vertex_reg) : '0;
            m_found_next    = hold_valid_reg;
            m_last_next     = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            directed_reg   <= 1'b1;
            present_reg    <= '0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NV; i++) begin
                edge_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            directed_reg   <= directed_next;
            present_reg    <= present_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            edge_reg       <= edge_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_vertex_reg <= hold_vertex_next;
        m_vertex_reg    <= m_vertex_next;
        m_found_reg     <= m_found_next;
        m_last_reg      <= m_last_next;
        if (step_push) begin
            stack_reg[depth_reg[IW-1:0]] <= cand_idx;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_visited_vertex = m_vertex_reg;
    assign m_found          = m_found_reg;
    assign m_last           = m_last_reg;

    `AMDFS_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DW'(NV), "walk stack depth overflow")
    `AMDFS_ASSERT_IMPL(a_idle_stack_empty, state_reg == ST_IDLE, stack_empty,
        "walk stack not empty while idle")
    `AMDFS_ASSERT_IMPL(a_top_visited, state_reg == ST_STEP && !stack_empty,
        visited_reg[top_vertex], "vertex on the walk stack is not visited")
    `AMDFS_ASSERT_IMPL(a_not_found_empty, flush_go && !hold_valid_reg, present_reg == '0,
        "not-found result with present vertices")
    `AMDFS_ASSERT_NEXT(a_flush_last, flush_go, m_valid && m_last,
        "final result of a walk not flagged")

endmodule
